>>> design/gde_pkg.sv
`default_nettype none

package gde_pkg;

    // table sizes
    localparam int MAX_FEATURES  = 1024;
    localparam int MAX_PARENTS   = 256;
    localparam int MAX_NEIGHBORS = 32;

    // widths that follow from the table sizes and field formats
    localparam int FEAT_W     = $clog2(MAX_FEATURES);
    localparam int PAR_W      = $clog2(MAX_PARENTS);
    localparam int SLOT_W     = $clog2(MAX_NEIGHBORS);
    localparam int LIST_W     = FEAT_W + 1;
    localparam int NCNT_W     = SLOT_W + 1;
    localparam int FCNT_W     = FEAT_W + 1;
    localparam int PCNT_W     = PAR_W + 1;
    localparam int VOL_W      = 32;
    localparam int SUM_W      = 42;
    localparam int FRAC_W     = 16;
    localparam int DIVD_W     = VOL_W + FRAC_W;
    localparam int DENS_W     = 32;
    localparam int IDX_W      = 10;
    localparam int NBI_W      = 10;
    localparam int OWNER_W    = 8;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    // operation codes
    typedef enum logic [2:0] {
        OP_LOAD_FEAT  = 3'd0,
        OP_LOAD_PAR   = 3'd1,
        OP_LOAD_NB    = 3'd2,
        OP_COMPUTE    = 3'd3,
        OP_READ_DENS  = 3'd4,
        OP_READ_CLAIM = 3'd5
    } op_t;

    // reply kinds
    typedef enum logic [1:0] {
        REPLY_DONE    = 2'd0,
        REPLY_DENSITY = 2'd1,
        REPLY_CLAIM   = 2'd2
    } reply_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FAR   = 2'd0,
        CFG_TRACK = 2'd1,
        CFG_FCNT  = 2'd2,
        CFG_PCNT  = 2'd3
    } cfg_idx_t;

    // controller states
    typedef enum logic [4:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_DECODE,
        ST_NB_LOAD,
        ST_RD_DENS,
        ST_RD_CLAIM,
        ST_CLR_CLAIM,
        ST_P_CHK,
        ST_P_LOAD,
        ST_F_CHK,
        ST_F_TEST,
        ST_OWN_RD,
        ST_OWN_EX,
        ST_L_RD,
        ST_L_LATCH,
        ST_NB_CHK,
        ST_NB_LATCH,
        ST_NB_RD,
        ST_NB_EX,
        ST_FINISH,
        ST_DIV
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic cap;
        logic clr_all;
        logic clr_claim;
        logic sweep_zero;
        logic sweep_inc;
        logic wr_feat;
        logic wr_par;
        logic rd_list_ld;
        logic wr_nb;
        logic rd_dens;
        logic rd_claim;
        logic put_dens;
        logic put_claim;
        logic put_done;
        logic sat_clr;
        logic p_first;
        logic p_inc;
        logic rd_pvol;
        logic par_begin;
        logic rd_feat_f;
        logic f_inc;
        logic own_start;
        logic count_rd;
        logic count_ex;
        logic lk_zero;
        logic lk_set1;
        logic rd_lcnt;
        logic lcnt_latch;
        logic rd_nb;
        logic nb_latch;
        logic i_inc;
        logic div_start;
        logic dens_wr_zero;
        logic dens_wr_q;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic out_full;
        logic sweep_end_all;
        logic sweep_end_feat;
        logic p_done;
        logic f_done;
        logic owner_match;
        logic i_done;
        logic lk;
        logic far;
        logic div_busy;
        logic sum_zero;
    } sts_t;

endpackage

`default_nettype wire

>>> design/gde_ram.sv
`default_nettype none

module gde_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

>>> design/gde_div.sv
`default_nettype none

module gde_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [gde_pkg::DIVD_W-1:0]   dividend,
    input  wire logic [gde_pkg::SUM_W-1:0]    divisor,
    output logic                              busy,
    output logic      [gde_pkg::DIVD_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(gde_pkg::DIVD_W);

    logic                         busy_reg, busy_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [gde_pkg::SUM_W-1:0]    rem_reg, rem_next;
    logic [gde_pkg::DIVD_W-1:0]   quo_reg, quo_next;
    logic [gde_pkg::SUM_W-1:0]    div_reg, div_next;
    logic [gde_pkg::SUM_W:0]      trial;
    logic [gde_pkg::SUM_W:0]      diff;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[gde_pkg::DIVD_W-1]};
        diff      = trial - {1'b0, div_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(gde_pkg::DIVD_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[gde_pkg::SUM_W-1:0];
                quo_next = {quo_reg[gde_pkg::DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[gde_pkg::SUM_W-1:0];
                quo_next = {quo_reg[gde_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> design/gde_dp.sv
`default_nettype none

module gde_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [gde_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic [3:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [gde_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic      [1:0]                        m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [gde_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire gde_pkg::cmd_t                     cmd,
    output gde_pkg::sts_t                          sts
);

    localparam int FM_W = gde_pkg::OWNER_W + gde_pkg::VOL_W;
    localparam int SM_W = 2 * gde_pkg::PAR_W + gde_pkg::VOL_W;
    localparam int DM_W = gde_pkg::DENS_W + 1;
    localparam int NM_DEPTH = gde_pkg::MAX_FEATURES * 2 * gde_pkg::MAX_NEIGHBORS;

    // configuration
    logic                           far_reg, track_reg;
    logic [gde_pkg::FCNT_W-1:0]     fcnt_reg;
    logic [gde_pkg::PCNT_W-1:0]     pcnt_reg;

    // captured item
    gde_pkg::op_t                   op_reg;
    logic [gde_pkg::IDX_W-1:0]      idx_reg;
    logic [gde_pkg::OWNER_W-1:0]    own_reg;
    logic [gde_pkg::VOL_W-1:0]      vol_reg;
    logic [gde_pkg::NBI_W-1:0]      nb_reg;
    logic                           kind_reg;

    // walk state
    logic [gde_pkg::LIST_W-1:0]     sweep_reg;
    logic [gde_pkg::PCNT_W-1:0]     p_reg;
    logic [gde_pkg::FCNT_W-1:0]     f_reg;
    logic [gde_pkg::FEAT_W-1:0]     fid_reg;
    logic                           lk_reg;
    logic [gde_pkg::NCNT_W-1:0]     n_reg, i_reg;
    logic [gde_pkg::VOL_W-1:0]      pv_reg;
    logic [gde_pkg::SUM_W-1:0]      sum_reg;
    logic                           ovf_reg, sat_reg;
    logic [gde_pkg::MAX_PARENTS-1:0] dvalid_reg;

    // result register
    logic                           out_valid_reg;
    gde_pkg::reply_t                kind_out_reg;
    logic [gde_pkg::DENS_W-1:0]     dens_out_reg;
    logic                           def_out_reg;
    logic [gde_pkg::PAR_W-1:0]      claim_out_reg;

    // memory ports
    logic [FM_W-1:0]                fm_rdata;
    logic [gde_pkg::VOL_W-1:0]      pm_rdata;
    logic [gde_pkg::NBI_W-1:0]      nm_rdata;
    logic [gde_pkg::NCNT_W-1:0]     cm_rdata;
    logic [DM_W-1:0]                dm_rdata;
    logic [SM_W-1:0]                sm_rdata;
    logic                           list_full;
    logic                           par_in_range;
    logic                           sm_new;
    logic                           sm_take;
    logic [gde_pkg::PAR_W-1:0]      cpar_new;
    logic [gde_pkg::VOL_W-1:0]      cvol_new;
    logic                           clr_any;
    logic [gde_pkg::FCNT_W-1:0]     nf;
    logic [gde_pkg::PCNT_W-1:0]     np;
    logic                           div_busy;
    logic [gde_pkg::DIVD_W-1:0]     quot;
    logic                           q_sat;
    logic [gde_pkg::DENS_W-1:0]     q_dens;

    assign list_full    = cm_rdata[gde_pkg::SLOT_W];
    assign par_in_range = (idx_reg[gde_pkg::IDX_W-1:gde_pkg::PAR_W] == '0);
    assign clr_any      = cmd.clr_all | cmd.clr_claim;
    assign nf = (fcnt_reg > gde_pkg::FCNT_W'(gde_pkg::MAX_FEATURES))
              ? gde_pkg::FCNT_W'(gde_pkg::MAX_FEATURES) : fcnt_reg;
    assign np = (pcnt_reg > gde_pkg::PCNT_W'(gde_pkg::MAX_PARENTS))
              ? gde_pkg::PCNT_W'(gde_pkg::MAX_PARENTS) : pcnt_reg;

    // visit tag, claim parent and claim volume of the feature being counted
    assign sm_new   = (sm_rdata[SM_W-1 -: gde_pkg::PAR_W] != p_reg[gde_pkg::PAR_W-1:0]);
    assign sm_take  = track_reg && (pv_reg > sm_rdata[gde_pkg::VOL_W-1:0]);
    assign cpar_new = sm_take ? p_reg[gde_pkg::PAR_W-1:0]
                              : sm_rdata[gde_pkg::VOL_W +: gde_pkg::PAR_W];
    assign cvol_new = sm_take ? pv_reg : sm_rdata[gde_pkg::VOL_W-1:0];

    // saturating density
    assign q_sat  = (quot[gde_pkg::DIVD_W-1:gde_pkg::DENS_W] != '0);
    assign q_dens = q_sat ? '1 : quot[gde_pkg::DENS_W-1:0];

    // feature owner and volume
    gde_ram #(.DATA_W(FM_W), .DEPTH(gde_pkg::MAX_FEATURES)) u_fmem (
        .clk   (clk),
        .we    (cmd.wr_feat),
        .waddr (idx_reg),
        .wdata ({own_reg, vol_reg}),
        .raddr (cmd.rd_feat_f ? f_reg[gde_pkg::FEAT_W-1:0] : fid_reg),
        .rdata (fm_rdata)
    );

    // parent volume
    gde_ram #(.DATA_W(gde_pkg::VOL_W), .DEPTH(gde_pkg::MAX_PARENTS)) u_pmem (
        .clk   (clk),
        .we    (cmd.wr_par && par_in_range),
        .waddr (idx_reg[gde_pkg::PAR_W-1:0]),
        .wdata (vol_reg),
        .raddr (p_reg[gde_pkg::PAR_W-1:0]),
        .rdata (pm_rdata)
    );

    // neighbor lists
    gde_ram #(.DATA_W(gde_pkg::NBI_W), .DEPTH(NM_DEPTH)) u_nmem (
        .clk   (clk),
        .we    (cmd.wr_nb && !list_full),
        .waddr ({idx_reg, kind_reg, cm_rdata[gde_pkg::SLOT_W-1:0]}),
        .wdata (nb_reg),
        .raddr ({f_reg[gde_pkg::FEAT_W-1:0], lk_reg, i_reg[gde_pkg::SLOT_W-1:0]}),
        .rdata (nm_rdata)
    );

    // neighbor list lengths
    gde_ram #(.DATA_W(gde_pkg::NCNT_W), .DEPTH(2 * gde_pkg::MAX_FEATURES)) u_cmem (
        .clk   (clk),
        .we    (cmd.clr_all || (cmd.wr_nb && !list_full)),
        .waddr (cmd.clr_all ? sweep_reg : {idx_reg, kind_reg}),
        .wdata (cmd.clr_all ? '0 : cm_rdata + 1'b1),
        .raddr (cmd.rd_list_ld ? {idx_reg, kind_reg}
                               : {f_reg[gde_pkg::FEAT_W-1:0], lk_reg}),
        .rdata (cm_rdata)
    );

    // density results, undefined flag on top
    gde_ram #(.DATA_W(DM_W), .DEPTH(gde_pkg::MAX_PARENTS)) u_dmem (
        .clk   (clk),
        .we    (cmd.dens_wr_zero || cmd.dens_wr_q),
        .waddr (p_reg[gde_pkg::PAR_W-1:0]),
        .wdata (cmd.dens_wr_zero ? {1'b1, {gde_pkg::DENS_W{1'b0}}} : {1'b0, q_dens}),
        .raddr (idx_reg[gde_pkg::PAR_W-1:0]),
        .rdata (dm_rdata)
    );

    // visit tag, claim parent, claim volume
    gde_ram #(.DATA_W(SM_W), .DEPTH(gde_pkg::MAX_FEATURES)) u_smem (
        .clk   (clk),
        .we    (clr_any || (cmd.count_ex && sm_new)),
        .waddr (clr_any ? sweep_reg[gde_pkg::FEAT_W-1:0] : fid_reg),
        .wdata (clr_any ? '0 : {p_reg[gde_pkg::PAR_W-1:0], cpar_new, cvol_new}),
        .raddr (cmd.rd_claim ? idx_reg : fid_reg),
        .rdata (sm_rdata)
    );

    gde_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({pv_reg, {gde_pkg::FRAC_W{1'b0}}}),
        .divisor  (sum_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_reg   <= 1'b0;
            track_reg <= 1'b0;
            fcnt_reg  <= '0;
            pcnt_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (gde_pkg::cfg_idx_t'(cfg_index))
                gde_pkg::CFG_FAR:   far_reg   <= cfg_data[0];
                gde_pkg::CFG_TRACK: track_reg <= cfg_data[0];
                gde_pkg::CFG_FCNT:  fcnt_reg  <= cfg_data[gde_pkg::FCNT_W-1:0];
                gde_pkg::CFG_PCNT:  pcnt_reg  <= cfg_data[gde_pkg::PCNT_W-1:0];
                default:            far_reg   <= far_reg;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg   <= gde_pkg::op_t'(s_tuser[2:0]);
            kind_reg <= s_tuser[3];
            idx_reg  <= s_tdata[9:0];
            own_reg  <= s_tdata[17:10];
            vol_reg  <= s_tdata[49:18];
            nb_reg   <= s_tdata[59:50];
        end
    end

    // walk counters and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg  <= '0;
            p_reg      <= '0;
            f_reg      <= '0;
            i_reg      <= '0;
            n_reg      <= '0;
            lk_reg     <= 1'b0;
            ovf_reg    <= 1'b0;
            sat_reg    <= 1'b0;
            dvalid_reg <= '0;
        end
        else
        begin
            if (cmd.sweep_zero)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_inc)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.p_first)
            begin
                p_reg <= gde_pkg::PCNT_W'(1);
            end
            else if (cmd.p_inc)
            begin
                p_reg <= p_reg + 1'b1;
            end
            if (cmd.par_begin)
            begin
                f_reg <= gde_pkg::FCNT_W'(1);
            end
            else if (cmd.f_inc)
            begin
                f_reg <= f_reg + 1'b1;
            end
            if (cmd.lcnt_latch)
            begin
                i_reg <= '0;
                n_reg <= (cm_rdata > gde_pkg::NCNT_W'(gde_pkg::MAX_NEIGHBORS))
                       ? gde_pkg::NCNT_W'(gde_pkg::MAX_NEIGHBORS) : cm_rdata;
            end
            else if (cmd.i_inc)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.lk_zero)
            begin
                lk_reg <= 1'b0;
            end
            else if (cmd.lk_set1)
            begin
                lk_reg <= 1'b1;
            end
            if (cmd.wr_nb && list_full)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.sat_clr)
            begin
                sat_reg <= 1'b0;
            end
            else if (cmd.dens_wr_q && q_sat)
            begin
                sat_reg <= 1'b1;
            end
            if (cmd.dens_wr_zero || cmd.dens_wr_q)
            begin
                dvalid_reg[p_reg[gde_pkg::PAR_W-1:0]] <= 1'b1;
            end
        end
    end

    // feature id, parent volume and volume sum
    always_ff @(posedge clk)
    begin
        if (cmd.own_start)
        begin
            fid_reg <= f_reg[gde_pkg::FEAT_W-1:0];
        end
        else if (cmd.nb_latch)
        begin
            fid_reg <= nm_rdata;
        end
        if (cmd.par_begin)
        begin
            pv_reg  <= pm_rdata;
            sum_reg <= '0;
        end
        else if (cmd.count_ex && sm_new)
        begin
            sum_reg <= sum_reg + gde_pkg::SUM_W'(fm_rdata[gde_pkg::VOL_W-1:0]);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.put_dens || cmd.put_claim || cmd.put_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put_done)
        begin
            kind_out_reg  <= gde_pkg::REPLY_DONE;
            dens_out_reg  <= '0;
            def_out_reg   <= 1'b0;
            claim_out_reg <= '0;
        end
        else if (cmd.put_dens)
        begin
            kind_out_reg  <= gde_pkg::REPLY_DENSITY;
            claim_out_reg <= '0;
            if (!par_in_range)
            begin
                dens_out_reg <= '0;
                def_out_reg  <= 1'b0;
            end
            else if (dvalid_reg[idx_reg[gde_pkg::PAR_W-1:0]])
            begin
                dens_out_reg <= dm_rdata[gde_pkg::DENS_W-1:0];
                def_out_reg  <= !dm_rdata[gde_pkg::DENS_W];
            end
            else
            begin
                dens_out_reg <= '0;
                def_out_reg  <= 1'b1;
            end
        end
        else if (cmd.put_claim)
        begin
            kind_out_reg  <= gde_pkg::REPLY_CLAIM;
            dens_out_reg  <= '0;
            def_out_reg   <= 1'b0;
            claim_out_reg <= sm_rdata[gde_pkg::VOL_W +: gde_pkg::PAR_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_out_reg;
    assign m_tdata  = {5'b0, sat_reg, ovf_reg, claim_out_reg, def_out_reg, dens_out_reg};

    // status
    always_comb
    begin
        sts.op             = op_reg;
        sts.out_full       = out_valid_reg;
        sts.sweep_end_all  = &sweep_reg;
        sts.sweep_end_feat = &sweep_reg[gde_pkg::FEAT_W-1:0];
        sts.p_done         = (p_reg >= np);
        sts.f_done         = (f_reg >= nf);
        sts.owner_match    = (fm_rdata[FM_W-1 -: gde_pkg::OWNER_W]
                              == p_reg[gde_pkg::PAR_W-1:0]);
        sts.i_done         = (i_reg == n_reg);
        sts.lk             = lk_reg;
        sts.far            = far_reg;
        sts.div_busy       = div_busy;
        sts.sum_zero       = (sum_reg == '0);
    end

endmodule

`default_nettype wire

>>> design/gde_ctrl.sv
`default_nettype none

module gde_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire gde_pkg::sts_t  sts,
    output gde_pkg::cmd_t       cmd
);

    gde_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gde_pkg::ST_INIT_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            gde_pkg::ST_INIT_CLR:
            begin
                cmd.clr_all   = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (sts.sweep_end_all)
                begin
                    state_next = gde_pkg::ST_IDLE;
                end
            end
            gde_pkg::ST_IDLE:
            begin
                s_tready = !sts.out_full;
                if (s_tvalid && !sts.out_full)
                begin
                    cmd.cap        = 1'b1;
                    cmd.sweep_zero = 1'b1;
                    state_next     = gde_pkg::ST_DECODE;
                end
            end
            gde_pkg::ST_DECODE:
            begin
                state_next = gde_pkg::ST_IDLE;
                unique case (sts.op)
                    gde_pkg::OP_LOAD_FEAT: cmd.wr_feat = 1'b1;
                    gde_pkg::OP_LOAD_PAR:  cmd.wr_par  = 1'b1;
                    gde_pkg::OP_LOAD_NB:
                    begin
                        cmd.rd_list_ld = 1'b1;
                        state_next     = gde_pkg::ST_NB_LOAD;
                    end
                    gde_pkg::OP_COMPUTE:
                    begin
                        cmd.sat_clr = 1'b1;
                        state_next  = gde_pkg::ST_CLR_CLAIM;
                    end
                    gde_pkg::OP_READ_DENS:
                    begin
                        cmd.rd_dens = 1'b1;
                        state_next  = gde_pkg::ST_RD_DENS;
                    end
                    gde_pkg::OP_READ_CLAIM:
                    begin
                        cmd.rd_claim = 1'b1;
                        state_next   = gde_pkg::ST_RD_CLAIM;
                    end
                    default: state_next = gde_pkg::ST_IDLE;
                endcase
            end
            gde_pkg::ST_NB_LOAD:
            begin
                cmd.wr_nb  = 1'b1;
                state_next = gde_pkg::ST_IDLE;
            end
            gde_pkg::ST_RD_DENS:
            begin
                cmd.put_dens = 1'b1;
                state_next   = gde_pkg::ST_IDLE;
            end
            gde_pkg::ST_RD_CLAIM:
            begin
                cmd.put_claim = 1'b1;
                state_next    = gde_pkg::ST_IDLE;
            end
            gde_pkg::ST_CLR_CLAIM:
            begin
                cmd.clr_claim = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (sts.sweep_end_feat)
                begin
                    cmd.p_first = 1'b1;
                    state_next  = gde_pkg::ST_P_CHK;
                end
            end
            gde_pkg::ST_P_CHK:
            begin
                if (sts.p_done)
                begin
                    cmd.put_done = 1'b1;
                    state_next   = gde_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.rd_pvol = 1'b1;
                    state_next  = gde_pkg::ST_P_LOAD;
                end
            end
            gde_pkg::ST_P_LOAD:
            begin
                cmd.par_begin = 1'b1;
                state_next    = gde_pkg::ST_F_CHK;
            end
            gde_pkg::ST_F_CHK:
            begin
                if (sts.f_done)
                begin
                    state_next = gde_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.rd_feat_f = 1'b1;
                    state_next    = gde_pkg::ST_F_TEST;
                end
            end
            gde_pkg::ST_F_TEST:
            begin
                if (sts.owner_match)
                begin
                    cmd.own_start = 1'b1;
                    state_next    = gde_pkg::ST_OWN_RD;
                end
                else
                begin
                    cmd.f_inc  = 1'b1;
                    state_next = gde_pkg::ST_F_CHK;
                end
            end
            gde_pkg::ST_OWN_RD:
            begin
                cmd.count_rd = 1'b1;
                state_next   = gde_pkg::ST_OWN_EX;
            end
            gde_pkg::ST_OWN_EX:
            begin
                cmd.count_ex = 1'b1;
                cmd.lk_zero  = 1'b1;
                state_next   = gde_pkg::ST_L_RD;
            end
            gde_pkg::ST_L_RD:
            begin
                cmd.rd_lcnt = 1'b1;
                state_next  = gde_pkg::ST_L_LATCH;
            end
            gde_pkg::ST_L_LATCH:
            begin
                cmd.lcnt_latch = 1'b1;
                state_next     = gde_pkg::ST_NB_CHK;
            end
            gde_pkg::ST_NB_CHK:
            begin
                if (!sts.i_done)
                begin
                    cmd.rd_nb  = 1'b1;
                    state_next = gde_pkg::ST_NB_LATCH;
                end
                else if (!sts.lk && sts.far)
                begin
                    cmd.lk_set1 = 1'b1;
                    state_next  = gde_pkg::ST_L_RD;
                end
                else
                begin
                    cmd.f_inc  = 1'b1;
                    state_next = gde_pkg::ST_F_CHK;
                end
            end
            gde_pkg::ST_NB_LATCH:
            begin
                cmd.nb_latch = 1'b1;
                state_next   = gde_pkg::ST_NB_RD;
            end
            gde_pkg::ST_NB_RD:
            begin
                cmd.count_rd = 1'b1;
                state_next   = gde_pkg::ST_NB_EX;
            end
            gde_pkg::ST_NB_EX:
            begin
                cmd.count_ex = 1'b1;
                cmd.i_inc    = 1'b1;
                state_next   = gde_pkg::ST_NB_CHK;
            end
            gde_pkg::ST_FINISH:
            begin
                if (sts.sum_zero)
                begin
                    cmd.dens_wr_zero = 1'b1;
                    cmd.p_inc        = 1'b1;
                    state_next       = gde_pkg::ST_P_CHK;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = gde_pkg::ST_DIV;
                end
            end
            gde_pkg::ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    cmd.dens_wr_q = 1'b1;
                    cmd.p_inc     = 1'b1;
                    state_next    = gde_pkg::ST_P_CHK;
                end
            end
            default: state_next = gde_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> design/grouping_density_engine.sv
`default_nettype none

// channel  direction  handshake            payload
// s_       in         s_tvalid / s_tready  s_tdata, s_tuser (operation item)
// m_       out        m_tvalid / m_tready  m_tdata, m_tuser (reply item)
// cfg_     in         cfg_we               cfg_index, cfg_data
//
// After reset a clearing pass wipes the list lengths and claim table; no item
// is taken until it ends. Compute clears the claim table, then per parent
// scans the features, walks the lists of each owned feature and counts each
// listed neighbour, and runs the serial divider when the sum is not zero.
// One item is handled at a time; a held reply stalls input.

module grouping_density_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // entry_index, owner_parent, volume_value, neighbor_index, zero pad
    input  wire logic [gde_pkg::IN_DATA_W-1:0]     s_tdata,
    // op, list_kind
    input  wire logic [3:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // density_value, density_defined, claiming_parent, list_overflow,
    // sum_saturated, zero pad
    output logic      [gde_pkg::OUT_DATA_W-1:0]    m_tdata,
    // reply_kind
    output logic      [1:0]                        m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [gde_pkg::CFG_DATA_W-1:0]    cfg_data
);

    gde_pkg::cmd_t cmd;
    gde_pkg::sts_t sts;

    gde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gde_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

>>> tb/grouping_density_engine_tb.sv
`default_nettype none

module grouping_density_engine_tb;
    import gde_pkg::*;

    // unused operation codes, ignored by the block
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 72;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [2:0]  op;
        logic [9:0]  idx;
        logic [7:0]  owner;
        logic [31:0] vol;
        logic [9:0]  nb;
        logic        kind;
    } op_item_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] dval;
        logic        ddef;
        logic [7:0]  claim;
        logic        ovf;
        logic        sat;
    } reply_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [3:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_we = 1'b0;
    logic [1:0]             cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    grouping_density_engine u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow copy of the block state
    logic        sh_far, sh_track;
    int          sh_fcnt, sh_pcnt;
    logic [7:0]  sh_owner [MAX_FEATURES];
    logic [31:0] sh_fvol [MAX_FEATURES];
    logic [31:0] sh_pvol [MAX_PARENTS];
    logic [9:0]  sh_nb [2*MAX_FEATURES][MAX_NEIGHBORS];
    int          sh_nbcnt [2*MAX_FEATURES];
    bit          sh_seen [MAX_FEATURES];
    logic [63:0] sh_sum;
    logic [31:0] sh_dens [MAX_PARENTS];
    bit          sh_undef [MAX_PARENTS];
    logic [7:0]  sh_cpar [MAX_FEATURES];
    logic [31:0] sh_cvol [MAX_FEATURES];
    logic        sh_ovf, sh_sat;

    // stimulus bookkeeping
    op_item_t    pending_ops [$];
    reply_item_t awaited_replies [$];
    bit          feat_loaded [MAX_FEATURES];
    bit          par_loaded [MAX_PARENTS];
    int          loaded_feats [$];
    int          in_flight = 0;
    int          err_count = 0;
    int          replies_seen = 0;
    int          computes_done = 0;
    bit          no_idle = 1'b0;

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // count one feature towards the current parent
    function automatic void tally_feature(int fid, int pid);
        if (fid >= MAX_FEATURES || sh_seen[fid])
            return;
        sh_seen[fid] = 1'b1;
        sh_sum = sh_sum + sh_fvol[fid];
        if (sh_track && sh_pvol[pid] > sh_cvol[fid])
        begin
            sh_cvol[fid] = sh_pvol[pid];
            sh_cpar[fid] = pid[7:0];
        end
    endfunction

    function automatic void tally_list(int fid, int kind, int pid);
        int lst;
        int n;
        lst = fid * 2 + kind;
        n = sh_nbcnt[lst] > MAX_NEIGHBORS ? MAX_NEIGHBORS : sh_nbcnt[lst];
        for (int i = 0; i < n; i++)
            tally_feature(sh_nb[lst][i], pid);
    endfunction

    // grouping density over parents 1 to np-1
    function automatic void compute_densities();
        int          nf;
        int          np;
        logic [63:0] q;
        nf = sh_fcnt < MAX_FEATURES ? sh_fcnt : MAX_FEATURES;
        np = sh_pcnt < MAX_PARENTS ? sh_pcnt : MAX_PARENTS;
        for (int i = 0; i < MAX_FEATURES; i++)
        begin
            sh_cpar[i] = '0;
            sh_cvol[i] = '0;
        end
        sh_sat = 1'b0;
        for (int p = 1; p < np; p++)
        begin
            for (int i = 0; i < MAX_FEATURES; i++)
                sh_seen[i] = 1'b0;
            sh_sum = '0;
            for (int f = 1; f < nf; f++)
            begin
                if (sh_owner[f] != p)
                    continue;
                tally_feature(f, p);
                tally_list(f, 0, p);
                if (sh_far)
                    tally_list(f, 1, p);
            end
            if (sh_sum == 0)
            begin
                sh_dens[p]  = '0;
                sh_undef[p] = 1'b1;
            end
            else
            begin
                q = {sh_pvol[p], 16'h0000} / sh_sum;
                if (q > 64'hFFFF_FFFF)
                begin
                    q = 64'hFFFF_FFFF;
                    sh_sat = 1'b1;
                end
                sh_dens[p]  = q[31:0];
                sh_undef[p] = 1'b0;
            end
        end
    endfunction

    // apply one accepted item to the shadow state, queue its reply if any
    function automatic void apply_op(op_item_t it);
        reply_item_t r;
        int          lst;
        case (it.op)
            OP_LOAD_FEAT:
            begin
                sh_owner[it.idx] = it.owner;
                sh_fvol[it.idx]  = it.vol;
                return;
            end
            OP_LOAD_PAR:
            begin
                if (it.idx < MAX_PARENTS)
                    sh_pvol[it.idx] = it.vol;
                return;
            end
            OP_LOAD_NB:
            begin
                lst = it.idx * 2 + it.kind;
                if (sh_nbcnt[lst] < MAX_NEIGHBORS)
                begin
                    sh_nb[lst][sh_nbcnt[lst]] = it.nb;
                    sh_nbcnt[lst]++;
                end
                else
                    sh_ovf = 1'b1;
                return;
            end
            OP_COMPUTE:
            begin
                compute_densities();
                computes_done++;
            end
            OP_READ_DENS, OP_READ_CLAIM: ;
            default: return;
        endcase
        r.kind  = 2'(it.op - OP_COMPUTE);
        r.dval  = '0;
        r.ddef  = 1'b0;
        r.claim = '0;
        if (it.op == OP_READ_DENS && it.idx < MAX_PARENTS)
        begin
            r.dval = sh_dens[it.idx];
            r.ddef = !sh_undef[it.idx];
        end
        if (it.op == OP_READ_CLAIM)
            r.claim = sh_cpar[it.idx];
        r.ovf = sh_ovf;
        r.sat = sh_sat;
        awaited_replies.push_back(r);
    endfunction

    task automatic push_op(logic [2:0] op, int idx, int owner, logic [31:0] vol,
                           int nb, int kind);
        op_item_t it;
        it.op = op;
        it.idx = idx[9:0];
        it.owner = owner[7:0];
        it.vol = vol;
        it.nb = nb[9:0];
        it.kind = kind[0];
        if (op == OP_LOAD_FEAT && !feat_loaded[idx])
        begin
            feat_loaded[idx] = 1'b1;
            loaded_feats.push_back(idx);
        end
        if (op == OP_LOAD_PAR && idx < MAX_PARENTS)
            par_loaded[idx] = 1'b1;
        in_flight++;
        pending_ops.push_back(it);
    endtask

    function automatic logic [31:0] rand_volume();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return 32'hFFFF_FFFF;
        else if (r < 6)
            return $urandom_range(1, 4096);
        else
            return $urandom;
    endfunction

    function automatic int pick_loaded();
        return loaded_feats[$urandom_range(0, loaded_feats.size() - 1)];
    endfunction

    task automatic write_reg(cfg_idx_t idx, int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_FAR:   sh_far   = val[0];
            CFG_TRACK: sh_track = val[0];
            CFG_FCNT:  sh_fcnt  = val & 11'h7FF;
            CFG_PCNT:  sh_pcnt  = val & 9'h1FF;
            default: ;
        endcase
    endtask

    task automatic set_config(int far, int track, int fcnt, int pcnt);
        write_reg(CFG_FAR, far);
        write_reg(CFG_TRACK, track);
        write_reg(CFG_FCNT, fcnt);
        write_reg(CFG_PCNT, pcnt);
    endtask

    // load every table entry that a compute at this setting will read
    task automatic fill_tables(int np);
        for (int f = 0; f < sh_fcnt && f < MAX_FEATURES; f++)
            if (!feat_loaded[f])
                push_op(OP_LOAD_FEAT, f, $urandom_range(0, np), rand_volume(), 0, 0);
        for (int p = 0; p < sh_pcnt && p < MAX_PARENTS; p++)
            if (!par_loaded[p])
                push_op(OP_LOAD_PAR, p, 0, rand_volume(), 0, 0);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (in_flight != 0 || awaited_replies.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        bit       busy;
        op_item_t cur;
        int       gap_cnt;
        if (rst_n)
        begin
            busy = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                apply_op(cur);
                in_flight--;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (gap_cnt > 0)
                    gap_cnt--;
                else if (pending_ops.size() > 0)
                begin
                    cur = pending_ops.pop_front();
                    s_tdata <= {4'b0, cur.nb, cur.vol, cur.owner, cur.idx};
                    s_tuser <= {cur.kind, cur.op};
                    busy = 1'b1;
                    gap_cnt = no_idle ? 0 : rand_gap();
                end
            end
            s_tvalid <= busy;
        end
    end

    // reply side back-pressure, with one long hold-off
    always @(posedge clk)
    begin
        int stall_cnt;
        int hold_cnt;
        bit long_done;
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (!long_done && replies_seen >= 40)
            begin
                long_done = 1'b1;
                hold_cnt = 600;
                m_tready <= 1'b0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall_cnt = no_idle ? 0 : rand_gap();
                m_tready <= (stall_cnt == 0);
            end
        end
    end

    // reply checker
    always @(posedge clk)
    begin
        reply_item_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            replies_seen++;
            if (awaited_replies.size() == 0)
            begin
                $error("unexpected reply item, kind %0d", m_tuser);
                err_count++;
            end
            else
            begin
                exp_r = awaited_replies.pop_front();
                if (m_tuser !== exp_r.kind)
                begin
                    $error("reply_kind: expected %0d, got %0d", exp_r.kind, m_tuser);
                    err_count++;
                end
                if (m_tdata[31:0] !== exp_r.dval)
                begin
                    $error("density_value: expected %h, got %h", exp_r.dval, m_tdata[31:0]);
                    err_count++;
                end
                if (m_tdata[32] !== exp_r.ddef)
                begin
                    $error("density_defined: expected %0d, got %0d", exp_r.ddef, m_tdata[32]);
                    err_count++;
                end
                if (m_tdata[40:33] !== exp_r.claim)
                begin
                    $error("claiming_parent: expected %0d, got %0d", exp_r.claim,
                           m_tdata[40:33]);
                    err_count++;
                end
                if (m_tdata[41] !== exp_r.ovf)
                begin
                    $error("list_overflow: expected %0d, got %0d", exp_r.ovf, m_tdata[41]);
                    err_count++;
                end
                if (m_tdata[42] !== exp_r.sat)
                begin
                    $error("sum_saturated: expected %0d, got %0d", exp_r.sat, m_tdata[42]);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        int cycles;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int fcnt;
        int pcnt;
        int issued;
        int r;
        int idx;
        for (int i = 0; i < MAX_FEATURES; i++)
        begin
            sh_owner[i] = '0; sh_fvol[i] = '0; sh_seen[i] = 1'b0;
            sh_cpar[i] = '0; sh_cvol[i] = '0;
        end
        for (int i = 0; i < 2*MAX_FEATURES; i++)
            sh_nbcnt[i] = 0;
        for (int i = 0; i < MAX_PARENTS; i++)
        begin
            sh_pvol[i] = '0; sh_dens[i] = '0; sh_undef[i] = 1'b0;
        end
        sh_far = 1'b0; sh_track = 1'b0; sh_fcnt = 0; sh_pcnt = 0;
        sh_ovf = 1'b0; sh_sat = 1'b0; sh_sum = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: shared neighbours, saturation, zero sum, zero-volume parent
        set_config(1, 1, 8, 4);
        push_op(OP_READ_DENS, 1, 0, 0, 0, 0);
        push_op(OP_LOAD_PAR, 0, 0, 5, 0, 0);
        push_op(OP_LOAD_PAR, 1, 0, 32'h100, 0, 0);
        push_op(OP_LOAD_PAR, 2, 0, 32'hFFFF_FFFF, 0, 0);
        push_op(OP_LOAD_PAR, 3, 0, 0, 0, 0);
        push_op(OP_LOAD_PAR, 1023, 0, 32'h7B, 0, 0);
        push_op(OP_LOAD_FEAT, 0, 1, 32'h55, 0, 0);
        push_op(OP_LOAD_FEAT, 1, 1, 32'h200, 0, 0);
        push_op(OP_LOAD_FEAT, 2, 2, 1, 0, 0);
        push_op(OP_LOAD_FEAT, 3, 255, 32'hFFFF_FFFF, 0, 0);
        push_op(OP_LOAD_FEAT, 4, 0, 32'h300, 0, 0);
        push_op(OP_LOAD_FEAT, 5, 1, 0, 0, 0);
        push_op(OP_LOAD_FEAT, 6, 3, 0, 0, 0);
        push_op(OP_LOAD_FEAT, 7, 1, 32'h1234, 0, 0);
        push_op(OP_LOAD_FEAT, 1023, 200, 7, 1023, 1);
        push_op(OP_LOAD_NB, 1, 0, 0, 0, 0);
        push_op(OP_LOAD_NB, 1, 0, 0, 1, 0);
        push_op(OP_LOAD_NB, 1, 0, 0, 1023, 1);
        push_op(OP_LOAD_NB, 7, 0, 0, 2, 0);
        push_op(OP_LOAD_NB, 7, 0, 0, 0, 0);
        push_op(OP_SPARE_A, 3, 0, 0, 0, 0);
        push_op(OP_SPARE_B, 1023, 255, 32'hFFFF_FFFF, 1023, 1);
        push_op(OP_COMPUTE, 0, 0, 0, 0, 0);
        for (int p = 0; p < 4; p++)
            push_op(OP_READ_DENS, p, 0, 0, 0, 0);
        push_op(OP_READ_DENS, 1023, 0, 0, 0, 0);
        for (int f = 0; f < 4; f++)
            push_op(OP_READ_CLAIM, f, 0, 0, 0, 0);
        push_op(OP_READ_CLAIM, 1023, 0, 0, 0, 0);
        // fill one list past its capacity
        for (int i = 0; i < MAX_NEIGHBORS + 1; i++)
            push_op(OP_LOAD_NB, 5, 0, 0, pick_loaded(), 0);
        push_op(OP_COMPUTE, 0, 0, 0, 0, 0);
        push_op(OP_READ_DENS, 1, 0, 0, 0, 0);
        wait_drained();

        // random phases, each at its own setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            fcnt = $urandom_range(2, 48);
            pcnt = $urandom_range(2, 10);
            if (ph == 3)
            begin
                fcnt = 320;
                pcnt = 3;
            end
            if (ph == 6)
            begin
                fcnt = 20;
                pcnt = MAX_PARENTS;
            end
            if (ph == 8)
            begin
                fcnt = 0;
                pcnt = 0;
            end
            no_idle = (ph % 4 == 2);
            set_config($urandom_range(0, 1), $urandom_range(0, 1), fcnt, pcnt);
            fill_tables(pcnt > 1 ? pcnt - 1 : 1);
            issued = 0;
            while (issued < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, fcnt > 1 ? fcnt - 1 : 1);
                issued++;
                if (r < 28)
                    push_op(OP_LOAD_FEAT, idx,
                            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, pcnt),
                            rand_volume(), $urandom_range(0, 1023), $urandom_range(0, 1));
                else if (r < 38)
                    push_op(OP_LOAD_PAR,
                            ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, pcnt),
                            $urandom_range(0, 255), rand_volume(), 0, 0);
                else if (r < 68)
                    push_op(OP_LOAD_NB, idx, $urandom_range(0, 255), $urandom,
                            pick_loaded(), $urandom_range(0, 1));
                else if (r < 73)
                    push_op(OP_COMPUTE, idx, 0, 0, 0, 0);
                else if (r < 86)
                    push_op(OP_READ_DENS,
                            ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, pcnt),
                            0, 0, 0, 0);
                else if (r < 98)
                    push_op(OP_READ_CLAIM, idx, 0, 0, 0, 0);
                else
                begin
                    push_op(($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B,
                            idx, 0, $urandom, 0, 0);
                    issued--;
                end
            end
            // close each phase with a compute and a few reads
            push_op(OP_COMPUTE, 0, 0, 0, 0, 0);
            for (int p = 0; p < 3; p++)
                push_op(OP_READ_DENS, $urandom_range(0, pcnt), 0, 0, 0, 0);
            wait_drained();
        end

        repeat (50) @(posedge clk);
        $display("covered %0d computes and %0d reply items over %0d settings",
                 computes_done, replies_seen, PHASES + 1);
        $display("list overflow seen: %0d, saturation seen in last compute: %0d",
                 sh_ovf, sh_sat);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
